// ===== sv/ohsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohsp_pkg
// Shared types and codes for the OBEX header stream parser: parse phases,
// header formats, result kinds, register indexes and the state record.
// ----------------------------------------------------------------------------
package ohsp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned CHAR_N_W = LEN_W - 1;
   localparam int unsigned TERM_W   = 3;
   localparam int unsigned ACC_W    = 24;
   localparam int unsigned IDX_W    = 2;

   localparam logic [TERM_W-1:0]   TERM_BYTES   = TERM_W'(4);
   localparam logic [LEN_W-1:0]    LEN_OVERHEAD = LEN_W'(3);
   localparam logic [LEN_W-1:0]    LEN_MIN_CHAR = LEN_W'(9);
   localparam logic [CHAR_N_W-1:0] CHAR_TRIM    = CHAR_N_W'(2);
   localparam logic [IDX_W-1:0]    IDX_LAST     = IDX_W'(3);

   typedef enum logic [2:0] {
      PH_CODE    = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_UNICODE = 3'd3,
      PH_TERM    = 3'd4,
      PH_SEQ     = 3'd5,
      PH_SINGLE  = 3'd6,
      PH_FOUR    = 3'd7
   } phase_type;

   // top two bits of a header code
   typedef enum logic [1:0] {
      FMT_UNICODE = 2'b00,
      FMT_SEQ     = 2'b01,
      FMT_SINGLE  = 2'b10,
      FMT_FOUR    = 2'b11
   } fmt_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHAR   = 3'd0,
      KIND_SEQ    = 3'd1,
      KIND_SINGLE = 3'd2,
      KIND_FOUR   = 3'd3,
      KIND_END    = 3'd4
   } kind_type;

   typedef enum logic {
      CSR_FORCED_A = 1'b0,
      CSR_FORCED_B = 1'b1
   } csr_index_type;

   typedef struct packed {
      phase_type           phase;
      logic [BYTE_W-1:0]   code;
      logic [BYTE_W-1:0]   len_high;
      logic [LEN_W-1:0]    remaining;
      logic [TERM_W-1:0]   term_left;
      logic [BYTE_W-1:0]   char_high;
      logic [ACC_W-1:0]    acc;
      logic [IDX_W-1:0]    acc_idx;
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   code;
      kind_type            kind;
      logic [VALUE_W-1:0]  value;
      logic                last;
   } result_type;

   function automatic fmt_type format_of(input logic [BYTE_W-1:0] code,
                                         input logic [BYTE_W-1:0] forced_a,
                                         input logic [BYTE_W-1:0] forced_b);
      fmt_type f;
      if (code == forced_a || code == forced_b) begin
         f = FMT_FOUR;
      end else begin
         f = fmt_type'(code[BYTE_W-1 -: 2]);
      end
      return f;
   endfunction

endpackage

// ===== sv/obex_header_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obex_header_stream_parser
// Parses a byte stream of OBEX headers into characters, bytes and integer
// values, flagging the last result of each header.
//
//   channel   dir  beat content
//   req_      in   one header byte
//   rsp_      out  header code, value, kind, last-of-header flag
//   csr_      in   forced four-byte header codes a and b
//
// one byte is taken every cycle while req_tready is high; a result appears in the
// cycle after its byte, held in the one-entry result register
// req_tready drops only while a result is held and rsp_tready is low
// synchronous reset returns the parser to expecting a header code and
// loads the forced codes with 0xf0 and 0xf1
// ----------------------------------------------------------------------------
module obex_header_stream_parser
   import ohsp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,    // data_byte

   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata,    // header_code [7:0], item_value [39:8]
   output logic [2:0]    rsp_tuser,    // item_kind
   output logic          rsp_tlast,    // header_last

   input  logic          csr_wr_en,
   input  logic          csr_addr,
   input  logic [7:0]    csr_wr_data
);

   state_type          state_ff, state_in, state_nxt;
   logic [BYTE_W-1:0]  forced_a_ff, forced_a_in;
   logic [BYTE_W-1:0]  forced_b_ff, forced_b_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               step_valid;
   result_type         step_res;
   logic               req_beat;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;

   ohsp_step u_step (
      .state_cur (state_ff),
      .data_byte (req_tdata),
      .forced_a  (forced_a_ff),
      .forced_b  (forced_b_ff),
      .state_nxt (state_nxt),
      .res_valid (step_valid),
      .res       (step_res)
   );

   always_comb begin
      forced_a_in = forced_a_ff;
      forced_b_in = forced_b_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_addr))
            CSR_FORCED_A: forced_a_in = csr_wr_data;
            CSR_FORCED_B: forced_b_in = csr_wr_data;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_beat) begin
         state_in = state_nxt;
         if (step_valid) begin
            rsp_valid_in = 1'b1;
            rsp_in       = step_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase     <= PH_CODE;
         state_ff.code      <= '0;
         state_ff.len_high  <= '0;
         state_ff.remaining <= '0;
         state_ff.term_left <= '0;
         state_ff.char_high <= '0;
         state_ff.acc       <= '0;
         state_ff.acc_idx   <= '0;
         forced_a_ff        <= 8'hf0;
         forced_b_ff        <= 8'hf1;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         forced_a_ff  <= forced_a_in;
         forced_b_ff  <= forced_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.value, rsp_ff.code};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

`ifndef SYNTHESIS
   a_term_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_TERM) |-> (state_ff.term_left != '0))
      else $error("terminator count empty while skipping terminators");

   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_UNICODE || state_ff.phase == PH_SEQ)
         |-> (state_ff.remaining != '0))
      else $error("body phase with nothing left");

   a_idx_in_four: assert property (@(posedge clock) disable iff (reset)
      (state_ff.acc_idx != '0) |-> (state_ff.phase == PH_FOUR))
      else $error("integer byte index set outside four-byte phase");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (req_beat && state_ff.phase == PH_SINGLE) |=> (rsp_tvalid && rsp_tlast))
      else $error("single-byte header gave no final result");
`endif

endmodule

// ===== sv/ohsp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohsp_step
// Next-state and result logic for one header byte: decodes the phase,
// tracks lengths and counters, and forms at most one result per byte.
// ----------------------------------------------------------------------------
module ohsp_step
   import ohsp_pkg::*;
(
   input  state_type          state_cur,
   input  logic [BYTE_W-1:0]  data_byte,
   input  logic [BYTE_W-1:0]  forced_a,
   input  logic [BYTE_W-1:0]  forced_b,
   output state_type          state_nxt,
   output logic               res_valid,
   output result_type         res
);

   fmt_type              fmt_cur;
   fmt_type              fmt_new;
   logic [LEN_W-1:0]     len;
   logic [LEN_W-1:0]     len_body;
   logic [CHAR_N_W-1:0]  char_count;
   logic [LEN_W-1:0]     rem_dec;
   logic [TERM_W-1:0]    term_dec;

   assign fmt_cur  = format_of(state_cur.code, forced_a, forced_b);
   assign fmt_new  = format_of(data_byte, forced_a, forced_b);
   assign len      = {state_cur.len_high, data_byte};
   assign len_body = len - LEN_OVERHEAD;
   assign char_count = (len >= LEN_MIN_CHAR) ? (len_body[LEN_W-1:1] - CHAR_TRIM)
                                             : '0;
   assign rem_dec  = state_cur.remaining - LEN_W'(1);
   assign term_dec = (state_cur.term_left != '0) ? state_cur.term_left - TERM_W'(1)
                                                 : state_cur.term_left;

   always_comb begin
      state_nxt  = state_cur;
      res_valid  = 1'b0;
      res.code   = state_cur.code;
      res.kind   = KIND_END;
      res.value  = '0;
      res.last   = 1'b0;

      unique case (state_cur.phase)
         PH_CODE: begin
            state_nxt.code = data_byte;
            unique case (fmt_new)
               FMT_SINGLE: begin
                  state_nxt.phase = PH_SINGLE;
               end
               FMT_FOUR: begin
                  state_nxt.acc     = '0;
                  state_nxt.acc_idx = '0;
                  state_nxt.phase   = PH_FOUR;
               end
               FMT_UNICODE, FMT_SEQ: begin
                  state_nxt.phase = PH_LEN_HI;
               end
            endcase
         end

         PH_LEN_HI: begin
            state_nxt.len_high = data_byte;
            state_nxt.phase    = PH_LEN_LO;
         end

         PH_LEN_LO: begin
            if (fmt_cur == FMT_UNICODE) begin
               state_nxt.term_left = TERM_BYTES;
               if (char_count == '0) begin
                  state_nxt.remaining = '0;
                  state_nxt.phase     = PH_TERM;
                  res_valid           = 1'b1;
                  res.last            = 1'b1;
               end else begin
                  state_nxt.remaining = {char_count, 1'b0};
                  state_nxt.phase     = PH_UNICODE;
               end
            end else if (len <= LEN_OVERHEAD) begin
               state_nxt.remaining = '0;
               state_nxt.phase     = PH_CODE;
               res_valid           = 1'b1;
               res.last            = 1'b1;
            end else begin
               state_nxt.remaining = len_body;
               state_nxt.phase     = PH_SEQ;
            end
         end

         PH_UNICODE: begin
            state_nxt.remaining = rem_dec;
            if (!state_cur.remaining[0]) begin
               state_nxt.char_high = data_byte;
            end else begin
               if (rem_dec == '0) begin
                  state_nxt.phase = PH_TERM;
               end
               res_valid = 1'b1;
               res.kind  = KIND_CHAR;
               res.value = {16'h0000, state_cur.char_high, data_byte};
               res.last  = (rem_dec == '0);
            end
         end

         PH_TERM: begin
            state_nxt.term_left = term_dec;
            if (term_dec == '0) begin
               state_nxt.phase = PH_CODE;
            end
         end

         PH_SEQ: begin
            state_nxt.remaining = rem_dec;
            if (rem_dec == '0) begin
               state_nxt.phase = PH_CODE;
            end
            res_valid = 1'b1;
            res.kind  = KIND_SEQ;
            res.value = {24'h000000, data_byte};
            res.last  = (rem_dec == '0);
         end

         PH_SINGLE: begin
            state_nxt.phase = PH_CODE;
            res_valid = 1'b1;
            res.kind  = KIND_SINGLE;
            res.value = {24'h000000, data_byte};
            res.last  = 1'b1;
         end

         PH_FOUR: begin
            if (state_cur.acc_idx != IDX_LAST) begin
               state_nxt.acc     = {state_cur.acc[ACC_W-BYTE_W-1:0], data_byte};
               state_nxt.acc_idx = state_cur.acc_idx + IDX_W'(1);
            end else begin
               state_nxt.acc_idx = '0;
               state_nxt.acc     = '0;
               state_nxt.phase   = PH_CODE;
               res_valid = 1'b1;
               res.kind  = KIND_FOUR;
               res.value = {state_cur.acc, data_byte};
               res.last  = 1'b1;
            end
         end
      endcase
   end

endmodule

// ===== bench/obex_header_stream_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obex_header_stream_parser_tb
// Self-checking bench for the OBEX header stream parser. Header bytes are
// streamed in and each result is compared with a parser model kept in the
// bench. The run begins with hand-picked headers: the four formats, empty
// strings and sequences, and the extreme values. Random headers follow,
// with mostly short lengths and a few longer ones. The forced four-byte
// codes change between phases. Each phase uses its own mix of input gaps
// and output stalls, and one long output stall fills the parser until it
// stops taking bytes.
// ----------------------------------------------------------------------------
module obex_header_stream_parser_tb;
   import ohsp_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;

   // parser model and the results it still owes
   class header_result_board;
      logic [7:0]  forced_a;
      logic [7:0]  forced_b;
      phase_type   phase;
      logic [7:0]  code;
      logic [7:0]  len_high;
      logic [16:0] remaining;
      logic [2:0]  term_left;
      logic [7:0]  char_high;
      logic [23:0] acc;
      logic [1:0]  acc_idx;
      result_type  due_results[$];
      int          errors;

      function new();
         forced_a  = 8'hF0;
         forced_b  = 8'hF1;
         phase     = PH_CODE;
         code      = '0;
         len_high  = '0;
         remaining = '0;
         term_left = '0;
         char_high = '0;
         acc       = '0;
         acc_idx   = '0;
         errors    = 0;
      endfunction

      function void set_forced(csr_index_type idx, logic [7:0] v);
         if (idx == CSR_FORCED_A) begin
            forced_a = v;
         end else begin
            forced_b = v;
         end
      endfunction

      function fmt_type header_format(logic [7:0] c);
         fmt_type f;
         f = fmt_type'(c[7:6]);
         if (c == forced_a || c == forced_b) begin
            f = FMT_FOUR;
         end
         return f;
      endfunction

      function void queue_result(kind_type k, logic [31:0] v, logic l);
         result_type r;
         r.code  = code;
         r.kind  = k;
         r.value = v;
         r.last  = l;
         due_results = {due_results, r};
      endfunction

      function void note_byte(logic [7:0] b);
         fmt_type     f;
         logic [15:0] len;
         int unsigned chars;
         f = header_format(code);
         case (phase)
            PH_CODE: begin
               code = b;
               f = header_format(b);
               if (f == FMT_SINGLE) begin
                  phase = PH_SINGLE;
               end else if (f == FMT_FOUR) begin
                  acc = '0;
                  acc_idx = '0;
                  phase = PH_FOUR;
               end else begin
                  phase = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               len_high = b;
               phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len = {len_high, b};
               if (f == FMT_UNICODE) begin
                  chars = (len >= 16'd9) ? ((int'(len) - 3) / 2 - 2) : 0;
                  term_left = 3'd4;
                  if (chars == 0) begin
                     remaining = '0;
                     phase = PH_TERM;
                     queue_result(KIND_END, '0, 1'b1);
                  end else begin
                     remaining = 17'(chars * 2);
                     phase = PH_UNICODE;
                  end
               end else if (len <= 16'd3) begin
                  remaining = '0;
                  phase = PH_CODE;
                  queue_result(KIND_END, '0, 1'b1);
               end else begin
                  remaining = 17'(len - 16'd3);
                  phase = PH_SEQ;
               end
            end
            PH_UNICODE: begin
               if (!remaining[0]) begin
                  char_high = b;
                  remaining = remaining - 1'b1;
               end else begin
                  remaining = remaining - 1'b1;
                  if (remaining == 0) begin
                     phase = PH_TERM;
                  end
                  queue_result(KIND_CHAR, {16'h0, char_high, b}, remaining == 0);
               end
            end
            PH_TERM: begin
               if (term_left != 0) begin
                  term_left = term_left - 1'b1;
               end
               if (term_left == 0) begin
                  phase = PH_CODE;
               end
            end
            PH_SEQ: begin
               remaining = remaining - 1'b1;
               if (remaining == 0) begin
                  phase = PH_CODE;
               end
               queue_result(KIND_SEQ, {24'h0, b}, remaining == 0);
            end
            PH_SINGLE: begin
               phase = PH_CODE;
               queue_result(KIND_SINGLE, {24'h0, b}, 1'b1);
            end
            default: begin
               if (acc_idx != 2'd3) begin
                  acc = {acc[15:0], b};
                  acc_idx = acc_idx + 1'b1;
               end else begin
                  acc_idx = '0;
                  phase = PH_CODE;
                  queue_result(KIND_FOUR, {acc, b}, 1'b1);
                  acc = '0;
               end
            end
         endcase
      endfunction

      function void check_result(logic [7:0] c, kind_type k, logic [31:0] v, logic l);
         result_type e;
         if (due_results.size() == 0) begin
            $error("unexpected result: code %0h kind %0d value %0h", c, k, v);
            errors++;
         end else begin
            e = due_results.pop_front();
            if (c !== e.code) begin
               $error("header_code: expected %0h, actual %0h", e.code, c);
               errors++;
            end
            if (k !== e.kind) begin
               $error("item_kind: expected %0d, actual %0d", e.kind, k);
               errors++;
            end
            if (v !== e.value) begin
               $error("item_value: expected %0h, actual %0h", e.value, v);
               errors++;
            end
            if (l !== e.last) begin
               $error("header_last: expected %0b, actual %0b", e.last, l);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic        csr_addr;
   logic [7:0]  csr_wr_data;

   // checking copy follows accepted beats, stream_plan follows generated ones
   header_result_board parser_sb   = new();
   header_result_board stream_plan = new();

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   obex_header_stream_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            parser_sb.note_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            parser_sb.check_result(rsp_tdata[7:0], kind_type'(rsp_tuser),
                                   rsp_tdata[39:8], rsp_tlast);
         end
      end
   end

   // receiver: random stalls, or a long hold-off while hold_left runs down
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // next byte that fits the planned parse state; length high bytes kept small
   function automatic logic [7:0] next_byte();
      logic [7:0] b;
      case (stream_plan.phase)
         PH_CODE: begin
            case ($urandom_range(7))
               0:       b = stream_plan.forced_a;
               1:       b = stream_plan.forced_b;
               default: b = 8'($urandom_range(255));
            endcase
         end
         PH_LEN_HI: b = ($urandom_range(99) < 5) ? 8'd1 : 8'd0;
         PH_LEN_LO: begin
            b = ($urandom_range(99) < 70) ? 8'($urandom_range(16)) : 8'($urandom_range(255));
         end
         default:   b = 8'($urandom_range(255));
      endcase
      return b;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      stream_plan.note_byte(b);
      stream_plan.due_results.delete();
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random(input int n);
      repeat (n) send_byte(next_byte());
      while (stream_plan.phase != PH_CODE) begin
         send_byte(next_byte());
      end
   endtask

   task automatic send_list(input logic [7:0] bytes[$]);
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (parser_sb.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_addr    <= idx;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      parser_sb.set_forced(idx, v);
      stream_plan.set_forced(idx, v);
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_addr    = CSR_FORCED_A;
      csr_wr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase 0: no idling, default forced codes
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      send_list('{8'hC0, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h80, 8'h00,
                  8'hBF, 8'hFF,
                  8'h42, 8'h00, 8'h03,
                  8'h48, 8'h00, 8'h05, 8'hAA, 8'h55,
                  8'h01, 8'h00, 8'h08, 8'h11, 8'h22, 8'h33, 8'h44,
                  8'h01, 8'h00, 8'h0A, 8'h12, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00});
      // long output hold-off while bytes keep coming
      hold_left = 300;
      send_random(60);
      send_random(90);
      wait_idle();

      // phase 1: sender idles
      write_csr(CSR_FORCED_A, 8'h00);
      write_csr(CSR_FORCED_B, 8'h41);
      req_idle_pct  = 78;
      rsp_stall_pct = 0;
      send_list('{8'h41, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
                  8'h00, 8'h12, 8'h34, 8'h56, 8'h78});
      send_random(140);
      wait_idle();

      // phase 2: receiver stalls
      write_csr(CSR_FORCED_A, 8'hFF);
      write_csr(CSR_FORCED_B, 8'h00);
      req_idle_pct  = 0;
      rsp_stall_pct = 78;
      send_random(140);
      wait_idle();

      // phase 3: both sides idle
      write_csr(CSR_FORCED_A, 8'h80);
      write_csr(CSR_FORCED_B, 8'hFF);
      req_idle_pct  = 36;
      rsp_stall_pct = 36;
      send_random(140);
      wait_idle();
      repeat (10) @(posedge clock);

      if (parser_sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== obex_header_stream_parser.f =====
sv/ohsp_pkg.sv
sv/ohsp_step.sv
sv/obex_header_stream_parser.sv
bench/obex_header_stream_parser_tb.sv
